@@ rtl/lic_pkg.sv @@
// ----------------------------------------------------------------------------
// lic_pkg: shared constants, codes and types of the LIC pixel engine
// Fixed-point formats, store geometry, opcodes and the store port bundles.
// ----------------------------------------------------------------------------
package lic_pkg;

   // store geometry
   localparam int MAX_WIDTH     = 128;
   localparam int MAX_HEIGHT    = 128;
   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int CW_X          = $clog2(MAX_WIDTH);
   localparam int CW_Y          = $clog2(MAX_HEIGHT);
   localparam int CW_MAX        = (CW_X > CW_Y) ? CW_X : CW_Y;
   localparam int DIM_RAW       = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                  $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int DIM_W         = (DIM_RAW > 8) ? DIM_RAW : 8;

   // filter and fixed point
   localparam int FILTER_SIZE   = 2048;
   localparam int IDX_W         = $clog2(FILTER_SIZE);
   localparam int FRACTION_BITS = 16;
   localparam int F             = FRACTION_BITS;
   localparam longint FX_ONE    = longint'(1) << F;
   localparam longint FX_VMIN   = (FX_ONE * 5 + 50) / 100;
   localparam longint FX_EPS    = (FX_ONE * 4 + 5000) / 10000;
   localparam longint FX_CLIP   = FX_ONE * 100000;

   // datapath widths
   localparam int KLEN_W  = 16 + F - 8;                      // kernel length in Q.F
   localparam int SEG_W   = F + 17;                          // holds the clip ceiling
   localparam int VEC_W   = F + 3;                           // scaled, negated component
   localparam int POS_W   = ((CW_MAX > 9) ? CW_MAX : 9) + F + 3;
   localparam int MA_W    = KLEN_W + 2;
   localparam int MB_W    = (VEC_W > 21) ? VEC_W : 21;
   localparam int MP_W    = MA_W + MB_W;
   localparam int STEP_W  = 10;
   localparam int TSUM_W  = IDX_W + 10;
   localparam int WSUM_W  = IDX_W + 1;
   localparam int DIV_NUM_W = 2 * F + 1;
   localparam int DIV_DEN_W = F + 2;

   // opcodes
   localparam logic [1:0] OP_WR_VECTOR = 2'd0;
   localparam logic [1:0] OP_WR_NOISE  = 2'd1;
   localparam logic [1:0] OP_COMPUTE   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_KERNEL_LENGTH   = 3'd0;
   localparam logic [2:0] REG_MAX_STEPS       = 3'd1;
   localparam logic [2:0] REG_LENGTH_TO_INDEX = 3'd2;
   localparam logic [2:0] REG_WIDTH_IN_USE    = 3'd3;
   localparam logic [2:0] REG_HEIGHT_IN_USE   = 3'd4;

   typedef struct packed {
      logic              vec_we;
      logic              noise_we;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       vec_data;
      logic [7:0]        noise_data;
   } store_wr_type;

   typedef struct packed {
      logic              vec_re;
      logic [ADDR_W-1:0] vec_addr;
      logic              noise_re;
      logic [ADDR_W-1:0] noise_addr;
   } store_rd_type;

   // row-major store address
   function automatic logic [ADDR_W-1:0] store_addr(input logic [CW_X-1:0] cx,
                                                    input logic [CW_Y-1:0] cy);
      return ADDR_W'(cy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx);
   endfunction

endpackage

@@ rtl/lic_div.sv @@
// ----------------------------------------------------------------------------
// lic_div: shared restoring divider
// Unsigned, one quotient bit per cycle; done pulses when quo is valid.
// ----------------------------------------------------------------------------
module lic_div
   import lic_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] work_ff, work_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;

   // one restoring step: shift in next dividend bit, trial subtract
   assign rem_sh = {rem_ff, work_ff[DIV_NUM_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W);
         work_in = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DEN_W-1:0];
         work_in = {work_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = work_ff;

endmodule

@@ rtl/lic_store.sv @@
// ----------------------------------------------------------------------------
// lic_store: vector-field and noise-texture memories
// One write port shared by both, one registered read port each.
// ----------------------------------------------------------------------------
module lic_store
   import lic_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output logic [31:0]  vec_rdata,
   output logic [7:0]   noise_rdata
);

   logic [31:0] vec_mem   [STORE_DEPTH];
   logic [7:0]  noise_mem [STORE_DEPTH];
   logic [31:0] vec_rdata_ff;
   logic [7:0]  noise_rdata_ff;

   // vector field: x component low half, y component high half
   always_ff @(posedge clock) begin
      if (wr.vec_we) begin
         vec_mem[wr.addr] <= wr.vec_data;
      end
      if (rd.vec_re) begin
         vec_rdata_ff <= vec_mem[rd.vec_addr];
      end
   end

   // noise texture
   always_ff @(posedge clock) begin
      if (wr.noise_we) begin
         noise_mem[wr.addr] <= wr.noise_data;
      end
      if (rd.noise_re) begin
         noise_rdata_ff <= noise_mem[rd.noise_addr];
      end
   end

   assign vec_rdata   = vec_rdata_ff;
   assign noise_rdata = noise_rdata_ff;

endmodule

@@ rtl/line_integral_convolution_pixel.sv @@
// Write transactions are taken in idle and leave the engine ready the next cycle.
// A compute transaction traces up to max_steps steps per direction, with 0..2 edge
// divides per step on the shared serial divider, then a normalizing divide unless
// the total weight is zero.
// The result sits in an output register; the engine is busy while tracing.
// Synchronous active-high reset clears control state and config to defaults.
// ----------------------------------------------------------------------------
// line_integral_convolution_pixel: LIC box-filter pixel engine
// Fills vector and noise stores, traces a streamline both ways from a pixel
// centre with one shared divider and multiplier, and normalizes the result.
// ----------------------------------------------------------------------------
module line_integral_convolution_pixel
   import lic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pixel_x, pixel_y, vector_x, vector_y, noise_value
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // intensity
   output logic [0:0]  rsp_tuser,   // zero_weight
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [19:0] csr_wdata
);

   typedef enum logic [18:0] {
      ST_IDLE    = 19'h00001,
      ST_START   = 19'h00002,
      ST_CHECK   = 19'h00004,
      ST_VWAIT   = 19'h00008,
      ST_EDGEX   = 19'h00010,
      ST_DIVX    = 19'h00020,
      ST_EDGEY   = 19'h00040,
      ST_DIVY    = 19'h00080,
      ST_ADV     = 19'h00100,
      ST_MULX    = 19'h00200,
      ST_MULY    = 19'h00400,
      ST_MULI    = 19'h00800,
      ST_NREAD   = 19'h01000,
      ST_NWAIT   = 19'h02000,
      ST_ACC     = 19'h04000,
      ST_DIRDONE = 19'h08000,
      ST_FIN     = 19'h10000,
      ST_DIVF    = 19'h20000,
      ST_OUT     = 19'h40000
   } state_type;

   localparam logic signed [VEC_W-1:0] VMIN_S = VEC_W'(FX_VMIN);
   localparam logic [SEG_W-1:0]        CLIP_U = SEG_W'(FX_CLIP);
   localparam logic [SEG_W-1:0]        EPS_U  = SEG_W'(FX_EPS);

   // ---------------- configuration registers ----------------
   logic [15:0] kernel_length_ff;
   logic [9:0]  max_steps_ff;
   logic [19:0] length_to_index_ff;
   logic [7:0]  width_in_use_ff;
   logic [7:0]  height_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_length_ff   <= 16'd2560;
         max_steps_ff       <= 10'd30;
         length_to_index_ff <= 20'd52403;
         width_in_use_ff    <= 8'd128;
         height_in_use_ff   <= 8'd128;
      end else if (csr_we) begin
         case (csr_addr)
            REG_KERNEL_LENGTH:   kernel_length_ff   <= csr_wdata[15:0];
            REG_MAX_STEPS:       max_steps_ff       <= csr_wdata[9:0];
            REG_LENGTH_TO_INDEX: length_to_index_ff <= csr_wdata;
            REG_WIDTH_IN_USE:    width_in_use_ff    <= csr_wdata[7:0];
            REG_HEIGHT_IN_USE:   height_in_use_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- input fields ----------------
   logic [6:0]  in_px, in_py;
   logic [15:0] in_vx, in_vy;
   logic [7:0]  in_noise;
   logic        req_acc;

   assign in_px    = req_tdata[6:0];
   assign in_py    = req_tdata[13:7];
   assign in_vx    = req_tdata[29:14];
   assign in_vy    = req_tdata[45:30];
   assign in_noise = req_tdata[53:46];

   // ---------------- state ----------------
   state_type                state_ff, state_in;
   logic                     dir_ff, dir_in;
   logic [DIM_W-1:0]         w_ff, w_in, h_ff, h_in;
   logic [CW_X-1:0]          sx0_ff, sx0_in;
   logic [CW_Y-1:0]          sy0_ff, sy0_in;
   logic signed [POS_W-1:0]  x_ff, x_in, y_ff, y_in, nx_ff, nx_in, ny_ff, ny_in;
   logic [KLEN_W-1:0]        cur_ff, cur_in;
   logic [SEG_W-1:0]         seg_ff, seg_in;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic signed [VEC_W-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [IDX_W-1:0]         idx_ff, idx_in, wacc_ff, wacc_in;
   logic [WSUM_W-1:0]        wsum_ff, wsum_in;
   logic [TSUM_W-1:0]        tsum_ff, tsum_in;
   logic [7:0]               res_int_ff, res_int_in;
   logic                     res_zw_ff, res_zw_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]               rsp_int_ff, rsp_int_in;
   logic                     rsp_zw_ff, rsp_zw_in;

   // shared multiplier, registered product
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [MP_W-1:0]   mul_ff, mul_in;

   // divider hookup
   logic                     div_start, div_done;
   logic [DIV_NUM_W-1:0]     div_num, div_quo;
   logic [DIV_DEN_W-1:0]     div_den;

   // stores
   store_wr_type             st_wr;
   store_rd_type             st_rd;
   logic [31:0]              vec_rdata;
   logic [7:0]               noise_rdata;

   // ---------------- helpers ----------------
   logic [KLEN_W-1:0]        klen;
   logic signed [MP_W-1:0]   mul_rnd, mul_adj, mul_shr;
   logic signed [POS_W-1:0]  mul_move;
   logic [DIM_W-1:0]         w_sat, h_sat, px_sat, py_sat;
   logic signed [15:0]       rx, ry;
   logic signed [VEC_W-1:0]  vx_raw, vy_raw;
   logic [F:0]               dist_x, dist_y;
   logic [DIV_DEN_W-1:0]     abs_vx, abs_vy;
   logic [SEG_W:0]           cur_sum;
   logic [MP_W-1:0]          idx_raw;
   logic signed [POS_W:0]    mid_x, mid_y;
   logic [DIM_W-1:0]         mcx, mcy;
   logic signed [POS_W-1:0]  wlim, hlim;
   logic                     out_free;

   // midpoint to store coordinate: truncate, halve, saturate to the field
   function automatic logic [DIM_W-1:0] mid_coord(input logic signed [POS_W:0] s,
                                                  input logic [DIM_W-1:0] lim);
      logic [POS_W:0] cw;
      logic [POS_W:0] lw;
      cw = (POS_W + 1)'(s[POS_W:F+1]);
      lw = (POS_W + 1)'(lim) - 1'b1;
      if (s[POS_W]) begin
         return '0;
      end else if (cw > lw) begin
         return DIM_W'(lw);
      end else begin
         return DIM_W'(cw);
      end
   endfunction

   assign klen = {kernel_length_ff, {(F - 8){1'b0}}};

   // truncate product / 2^F toward zero
   assign mul_rnd  = mul_ff[MP_W-1] ? MP_W'(FX_ONE - 1) : '0;
   assign mul_adj  = mul_ff + mul_rnd;
   assign mul_shr  = mul_adj >>> F;
   assign mul_move = $signed(mul_shr[POS_W-1:0]);

   // field size and seed saturation
   assign w_sat  = (width_in_use_ff == 8'd0) ? DIM_W'(1) :
                   (DIM_W'(width_in_use_ff) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) :
                   DIM_W'(width_in_use_ff);
   assign h_sat  = (height_in_use_ff == 8'd0) ? DIM_W'(1) :
                   (DIM_W'(height_in_use_ff) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
                   DIM_W'(height_in_use_ff);
   assign px_sat = (DIM_W'(in_px) > w_sat - 1'b1) ? w_sat - 1'b1 : DIM_W'(in_px);
   assign py_sat = (DIM_W'(in_py) > h_sat - 1'b1) ? h_sat - 1'b1 : DIM_W'(in_py);

   // vector components scaled from Q2.14 to Q.F, negated on the backward trace
   assign rx     = $signed(vec_rdata[15:0]);
   assign ry     = $signed(vec_rdata[31:16]);
   assign vx_raw = VEC_W'(rx) <<< (F - 14);
   assign vy_raw = VEC_W'(ry) <<< (F - 14);

   // distance to the next pixel edge along each axis
   assign dist_x = vx_ff[VEC_W-1] ? {1'b0, x_ff[F-1:0]} :
                   (F + 1)'(FX_ONE) - {1'b0, x_ff[F-1:0]};
   assign dist_y = vy_ff[VEC_W-1] ? {1'b0, y_ff[F-1:0]} :
                   (F + 1)'(FX_ONE) - {1'b0, y_ff[F-1:0]};
   assign abs_vx = DIV_DEN_W'(vx_ff[VEC_W-1] ? -vx_ff : vx_ff);
   assign abs_vy = DIV_DEN_W'(vy_ff[VEC_W-1] ? -vy_ff : vy_ff);

   assign cur_sum = (SEG_W + 1)'(cur_ff) + (SEG_W + 1)'(seg_ff);
   assign idx_raw = MP_W'(mul_ff >>> (F + 8));
   assign mid_x   = (POS_W + 1)'(x_ff) + (POS_W + 1)'(nx_ff);
   assign mid_y   = (POS_W + 1)'(y_ff) + (POS_W + 1)'(ny_ff);
   assign mcx     = mid_coord(mid_x, w_ff);
   assign mcy     = mid_coord(mid_y, h_ff);
   assign wlim    = $signed(POS_W'({w_ff, {F{1'b0}}}));
   assign hlim    = $signed(POS_W'({h_ff, {F{1'b0}}}));
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // store writes come straight from accepted write transactions
   always_comb begin
      st_wr.addr       = store_addr(CW_X'(in_px), CW_Y'(in_py));
      st_wr.vec_data   = {in_vy, in_vx};
      st_wr.noise_data = in_noise;
      st_wr.vec_we     = req_acc && (req_tuser == OP_WR_VECTOR) &&
                         (int'(in_px) < MAX_WIDTH) && (int'(in_py) < MAX_HEIGHT);
      st_wr.noise_we   = req_acc && (req_tuser == OP_WR_NOISE) &&
                         (int'(in_px) < MAX_WIDTH) && (int'(in_py) < MAX_HEIGHT);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULX: begin
            mul_a = $signed(MA_W'(seg_ff[KLEN_W:0]));
            mul_b = MB_W'(vx_ff);
         end
         ST_MULY: begin
            mul_a = $signed(MA_W'(seg_ff[KLEN_W:0]));
            mul_b = MB_W'(vy_ff);
         end
         ST_MULI: begin
            mul_a = $signed(MA_W'(cur_ff));
            mul_b = $signed(MB_W'(length_to_index_ff));
         end
         ST_NWAIT: begin
            mul_a = $signed(MA_W'(noise_rdata));
            mul_b = $signed(MB_W'(idx_ff - wacc_ff));
         end
         default: ;
      endcase
   end
   assign mul_in = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      sx0_in        = sx0_ff;
      sy0_in        = sy0_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      cur_in        = cur_ff;
      seg_in        = seg_ff;
      steps_in      = steps_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      idx_in        = idx_ff;
      wacc_in       = wacc_ff;
      wsum_in       = wsum_ff;
      tsum_in       = tsum_ff;
      res_int_in    = res_int_ff;
      res_zw_in     = res_zw_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_int_in    = rsp_int_ff;
      rsp_zw_in     = rsp_zw_ff;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      st_rd.vec_re     = 1'b0;
      st_rd.vec_addr   = store_addr(x_ff[F +: CW_X], y_ff[F +: CW_Y]);
      st_rd.noise_re   = 1'b0;
      st_rd.noise_addr = store_addr(CW_X'(mcx), CW_Y'(mcy));

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == OP_COMPUTE)) begin
               w_in     = w_sat;
               h_in     = h_sat;
               sx0_in   = CW_X'(px_sat);
               sy0_in   = CW_Y'(py_sat);
               dir_in   = 1'b0;
               wsum_in  = '0;
               tsum_in  = '0;
               state_in = ST_START;
            end
         end
         // seed at the pixel centre
         ST_START: begin
            x_in     = $signed(POS_W'({sx0_ff, 1'b1, {(F - 1){1'b0}}}));
            y_in     = $signed(POS_W'({sy0_ff, 1'b1, {(F - 1){1'b0}}}));
            cur_in   = '0;
            steps_in = '0;
            wacc_in  = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((cur_ff < klen) && (steps_ff < max_steps_ff)) begin
               st_rd.vec_re = 1'b1;
               state_in     = ST_VWAIT;
            end else begin
               state_in = ST_DIRDONE;
            end
         end
         // zero vector stops this direction
         ST_VWAIT: begin
            if ((rx == 16'sd0) && (ry == 16'sd0)) begin
               if (steps_ff == '0) begin
                  wacc_in = IDX_W'(1);
               end
               state_in = ST_DIRDONE;
            end else begin
               vx_in    = dir_ff ? -vx_raw : vx_raw;
               vy_in    = dir_ff ? -vy_raw : vy_raw;
               state_in = ST_EDGEX;
            end
         end
         ST_EDGEX: begin
            if ((vx_ff > VMIN_S) || (vx_ff < -VMIN_S)) begin
               div_start = 1'b1;
               div_num   = {dist_x, {F{1'b0}}};
               div_den   = abs_vx;
               state_in  = ST_DIVX;
            end else begin
               seg_in   = CLIP_U;
               state_in = ST_EDGEY;
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               seg_in   = SEG_W'(div_quo);
               state_in = ST_EDGEY;
            end
         end
         ST_EDGEY: begin
            if ((vy_ff > VMIN_S) || (vy_ff < -VMIN_S)) begin
               div_start = 1'b1;
               div_num   = {dist_y, {F{1'b0}}};
               div_den   = abs_vy;
               state_in  = ST_DIVY;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               if (SEG_W'(div_quo) < seg_ff) begin
                  seg_in = SEG_W'(div_quo);
               end
               state_in = ST_ADV;
            end
         end
         // advance arc length, cut at the kernel length
         ST_ADV: begin
            if (cur_sum > (SEG_W + 1)'(klen)) begin
               cur_in = klen;
               seg_in = SEG_W'(klen - cur_ff);
            end else begin
               cur_in = cur_sum[KLEN_W-1:0];
               seg_in = seg_ff + EPS_U;
            end
            state_in = ST_MULX;
         end
         ST_MULX: begin
            state_in = ST_MULY;
         end
         ST_MULY: begin
            nx_in    = x_ff + mul_move;
            state_in = ST_MULI;
         end
         ST_MULI: begin
            ny_in    = y_ff + mul_move;
            state_in = ST_NREAD;
         end
         // filter index and midpoint noise fetch
         ST_NREAD: begin
            if (idx_raw > MP_W'(FILTER_SIZE - 1)) begin
               idx_in = IDX_W'(FILTER_SIZE - 1);
            end else begin
               idx_in = IDX_W'(idx_raw);
            end
            st_rd.noise_re = 1'b1;
            state_in       = ST_NWAIT;
         end
         ST_NWAIT: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            tsum_in  = tsum_ff + mul_ff[TSUM_W-1:0];
            wacc_in  = idx_ff;
            steps_in = steps_ff + 1'b1;
            x_in     = nx_ff;
            y_in     = ny_ff;
            if (nx_ff[POS_W-1] || (nx_ff >= wlim) || ny_ff[POS_W-1] || (ny_ff >= hlim)) begin
               state_in = ST_DIRDONE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DIRDONE: begin
            wsum_in = wsum_ff + WSUM_W'(wacc_ff);
            if (!dir_ff) begin
               dir_in   = 1'b1;
               state_in = ST_START;
            end else begin
               state_in = ST_FIN;
            end
         end
         // normalize by total weight
         ST_FIN: begin
            if (wsum_ff == '0) begin
               res_int_in = '0;
               res_zw_in  = 1'b1;
               state_in   = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(tsum_ff);
               div_den   = DIV_DEN_W'(wsum_ff);
               state_in  = ST_DIVF;
            end
         end
         ST_DIVF: begin
            if (div_done) begin
               res_int_in = (div_quo > DIV_NUM_W'(255)) ? 8'd255 : div_quo[7:0];
               res_zw_in  = 1'b0;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_int_in    = res_int_ff;
               rsp_zw_in     = res_zw_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      dir_ff     <= dir_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      sx0_ff     <= sx0_in;
      sy0_ff     <= sy0_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      cur_ff     <= cur_in;
      seg_ff     <= seg_in;
      steps_ff   <= steps_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      idx_ff     <= idx_in;
      wacc_ff    <= wacc_in;
      wsum_ff    <= wsum_in;
      tsum_ff    <= tsum_in;
      res_int_ff <= res_int_in;
      res_zw_ff  <= res_zw_in;
      rsp_int_ff <= rsp_int_in;
      rsp_zw_ff  <= rsp_zw_in;
      mul_ff     <= mul_in;
   end

   lic_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   lic_store u_store (
      .clock       (clock),
      .wr          (st_wr),
      .rd          (st_rd),
      .vec_rdata   (vec_rdata),
      .noise_rdata (noise_rdata)
   );

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_int_ff;
   assign rsp_tuser[0] = rsp_zw_ff;

endmodule

@@ tb/line_integral_convolution_pixel_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_integral_convolution_pixel_tb: self-checking bench of the LIC pixel engine
// Loads the store region that the traced fields reach (an 8x8 corner, row 0
// and column 0), then runs directed and random transactions over several
// register settings. Each compute result is checked against an in-bench
// streamline tracer, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module line_integral_convolution_pixel_tb;
   import lic_pkg::*;

   typedef struct {
      logic [1:0]  op;
      logic [6:0]  px;
      logic [6:0]  py;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [7:0]  nz;
   } pixel_req_t;

   typedef struct {
      logic [7:0] intensity;
      logic       zero_weight;
   } pixel_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // pixel_x, pixel_y, vector_x, vector_y, noise_value
   logic [1:0]  req_tuser = '0;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // intensity
   logic [0:0]  rsp_tuser;        // zero_weight
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [19:0] csr_wdata = '0;

   // bench copy of stores and registers
   logic [31:0] vec_mirror [STORE_DEPTH];
   logic [7:0]  noise_mirror [STORE_DEPTH];
   longint      kernel_len_q, step_limit_q, len_to_idx_q, field_w_q, field_h_q;

   pixel_req_t  pending_reqs [$];
   pixel_rsp_t  expected_pixels [$];
   pixel_req_t  in_flight;
   bit          launch;
   bit          quiet = 1'b0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          mismatches = 0;

   line_integral_convolution_pixel uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint clamp_cell(longint p, longint lim);
      longint c;
      c = (p < 0) ? 0 : p / FX_ONE;
      return (c > lim - 1) ? lim - 1 : c;
   endfunction

   // distance along v to the next cell edge, optionally kept below seg
   function automatic longint edge_dist(longint pos, longint v, longint seg, bit keep_min);
      longint fl, t;
      fl = (pos / FX_ONE) * FX_ONE;
      if (v < -FX_VMIN) t = ((fl - pos) * FX_ONE) / v;
      else if (v > FX_VMIN) t = ((fl + FX_ONE - pos) * FX_ONE) / v;
      else return seg;
      if (keep_min && t >= seg) return seg;
      return t;
   endfunction

   // one direction of the streamline; returns texture sum, weight via wacc
   function automatic longint trace_dir(longint px, longint py, bit backward, longint w,
                                        longint h, output longint wacc);
      longint klen, cur, x, y, vx, vy, seg, prv, nx, ny, sx, sy, idx, tacc, steps;
      logic [31:0] e;
      klen = kernel_len_q <<< (FRACTION_BITS - 8);
      cur = 0;
      x = px * FX_ONE + FX_ONE / 2;
      y = py * FX_ONE + FX_ONE / 2;
      steps = 0;
      tacc = 0;
      wacc = 0;
      while (cur < klen && steps < step_limit_q) begin
         e = vec_mirror[clamp_cell(y, h) * MAX_WIDTH + clamp_cell(x, w)];
         if (e == 32'd0) begin
            if (steps == 0) wacc = 1;
            break;
         end
         vx = longint'(shortint'(e[15:0])) * FX_ONE / 16384;
         vy = longint'(shortint'(e[31:16])) * FX_ONE / 16384;
         if (backward) begin
            vx = -vx;
            vy = -vy;
         end
         seg = edge_dist(x, vx, FX_CLIP, 1'b0);
         seg = edge_dist(y, vy, seg, 1'b1);
         prv = cur;
         cur += seg;
         seg += FX_EPS;
         if (cur > klen) begin
            cur = klen;
            seg = klen - prv;
         end
         nx = x + vx * seg / FX_ONE;
         ny = y + vy * seg / FX_ONE;
         sx = clamp_cell((x + nx) / 2, w);
         sy = clamp_cell((y + ny) / 2, h);
         idx = (cur * len_to_idx_q) >>> (FRACTION_BITS + 8);
         if (idx > FILTER_SIZE - 1) idx = FILTER_SIZE - 1;
         tacc += longint'(noise_mirror[sy * MAX_WIDTH + sx]) * (idx - wacc);
         wacc = idx;
         steps++;
         x = nx;
         y = ny;
         if (x < 0 || x >= w * FX_ONE || y < 0 || y >= h * FX_ONE) break;
      end
      return tacc;
   endfunction

   // apply an accepted transaction to the mirror, queue the expected pixel
   function automatic void convolve_pixel(pixel_req_t r);
      longint w, h, px, py, t0, t1, w0, w1, q;
      pixel_rsp_t p;
      if (r.op == OP_WR_VECTOR) begin
         vec_mirror[r.py * MAX_WIDTH + r.px] = {r.vy, r.vx};
      end else if (r.op == OP_WR_NOISE) begin
         noise_mirror[r.py * MAX_WIDTH + r.px] = r.nz;
      end else if (r.op == OP_COMPUTE) begin
         w = (field_w_q < 1) ? 1 : (field_w_q > MAX_WIDTH) ? MAX_WIDTH : field_w_q;
         h = (field_h_q < 1) ? 1 : (field_h_q > MAX_HEIGHT) ? MAX_HEIGHT : field_h_q;
         px = (r.px > w - 1) ? w - 1 : r.px;
         py = (r.py > h - 1) ? h - 1 : r.py;
         t0 = trace_dir(px, py, 1'b0, w, h, w0);
         t1 = trace_dir(px, py, 1'b1, w, h, w1);
         if (w0 + w1 <= 0) begin
            p.intensity = 8'd0;
            p.zero_weight = 1'b1;
         end else begin
            q = (t0 + t1 < 0) ? 0 : (t0 + t1) / (w0 + w1);
            p.intensity = (q > 255) ? 8'd255 : q[7:0];
            p.zero_weight = 1'b0;
         end
         expected_pixels.push_back(p);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         launch = req_tvalid;
         if (req_tvalid && req_tready) begin
            convolve_pixel(in_flight);
            launch = 1'b0;
         end
         if (!launch) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               in_flight = pending_reqs.pop_front();
               req_tdata <= {2'b00, in_flight.nz, in_flight.vy, in_flight.vx,
                             in_flight.py, in_flight.px};
               req_tuser <= in_flight.op;
               launch = 1'b1;
               send_gap = quiet ? 0 : $urandom_range(0, 4);
            end
         end
         req_tvalid <= launch;
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel: intensity %0d zero_weight %0d",
                        rsp_tdata, rsp_tuser);
         end else begin
            pixel_rsp_t p;
            p = expected_pixels.pop_front();
            if (rsp_tdata !== p.intensity || rsp_tuser[0] !== p.zero_weight) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected %0d/%0d, got %0d/%0d",
                           p.intensity, p.zero_weight, rsp_tdata, rsp_tuser);
            end
         end
         recv_stall = quiet ? 0 : $urandom_range(0, 4);
         rsp_tready <= (recv_stall == 0);
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= (recv_stall == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic add_req(logic [1:0] op, logic [6:0] x, logic [6:0] y,
                          logic [15:0] vx, logic [15:0] vy, logic [7:0] nz);
      pixel_req_t r;
      r.op = op;
      r.px = x;
      r.py = y;
      r.vx = vx;
      r.vy = vy;
      r.nz = nz;
      pending_reqs.push_back(r);
   endtask

   // sampled mid-cycle so the driver's update of the same edge is settled
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(negedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_KERNEL_LENGTH:   kernel_len_q = val[15:0];
         REG_MAX_STEPS:       step_limit_q = val[9:0];
         REG_LENGTH_TO_INDEX: len_to_idx_q = val;
         REG_WIDTH_IN_USE:    field_w_q = val[7:0];
         REG_HEIGHT_IN_USE:   field_h_q = val[7:0];
         default: ;
      endcase
   endtask

   // vector mix: zero, below threshold, one axis, full range
   function automatic logic [31:0] rand_vector();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 32'd0;
      if (k == 1) return {16'($urandom_range(0, 1638) - 819), 16'($urandom_range(0, 1638) - 819)};
      if (k == 2) return {16'd0, 16'($urandom)};
      if (k == 3) return {16'($urandom), 16'd0};
      return $urandom;
   endfunction

   // kernel length, step limit, length to index, width, height
   // every field stays inside the loaded region: 8x8 corner, row 0 or column 0
   int phase_cfg [8][5] = '{
      '{2560, 30, 52403, 8, 8},
      '{256, 3, 1048575, 1, 1},
      '{65535, 4, 1, 128, 1},
      '{1, 1023, 8000, 8, 8},
      '{768, 0, 52403, 8, 8},
      '{512, 6, 20000, 0, 200},
      '{1024, 8, 52403, 200, 0},
      '{2000, 10, 3000, 8, 5}
   };

   initial begin
      int fw, fh, k;
      logic [31:0] v;
      logic [6:0] x, y;
      kernel_len_q = 2560;
      step_limit_q = 30;
      len_to_idx_q = 52403;
      field_w_q = 128;
      field_h_q = 128;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // keep the field inside the loaded region from the start
      write_reg(REG_WIDTH_IN_USE, 20'd8);
      write_reg(REG_HEIGHT_IN_USE, 20'd8);

      // load the 8x8 corner, row 0 and column 0 of both stores
      for (int yy = 0; yy < MAX_HEIGHT; yy++) begin
         for (int xx = 0; xx < MAX_WIDTH; xx++) begin
            if ((xx < 8 && yy < 8) || xx == 0 || yy == 0) begin
               v = rand_vector();
               add_req(OP_WR_VECTOR, 7'(xx), 7'(yy), v[15:0], v[31:16], 8'd0);
               add_req(OP_WR_NOISE, 7'(xx), 7'(yy), '0, '0, 8'($urandom));
            end
         end
      end
      drain();

      // directed: field extremes, zero and small vectors, unused opcode
      add_req(OP_WR_VECTOR, 0, 0, 16'h8000, 16'h8000, 8'h00);
      add_req(OP_WR_VECTOR, 127, 127, 16'h7fff, 16'h7fff, 8'h00);
      add_req(OP_WR_NOISE, 0, 0, '0, '0, 8'hff);
      add_req(OP_WR_NOISE, 127, 127, '1, '1, 8'h00);
      add_req(OP_COMPUTE, 0, 0, '0, '0, '0);
      add_req(OP_COMPUTE, 127, 127, '1, '1, '1);
      add_req(OP_WR_VECTOR, 5, 5, 16'd0, 16'd0, 8'h00);
      add_req(OP_COMPUTE, 5, 5, '0, '0, '0);
      add_req(OP_WR_VECTOR, 6, 6, 16'd819, -16'sd819, 8'h00);
      add_req(OP_COMPUTE, 6, 6, '0, '0, '0);
      add_req(2'd3, 7'h7f, 7'h7f, 16'hffff, 16'hffff, 8'hff);
      add_req(OP_COMPUTE, 64, 64, '0, '0, '0);
      drain();

      // random phases over register settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_KERNEL_LENGTH, 20'(phase_cfg[ph][0]));
         write_reg(REG_MAX_STEPS, 20'(phase_cfg[ph][1]));
         write_reg(REG_LENGTH_TO_INDEX, 20'(phase_cfg[ph][2]));
         write_reg(REG_WIDTH_IN_USE, 20'(phase_cfg[ph][3]));
         write_reg(REG_HEIGHT_IN_USE, 20'(phase_cfg[ph][4]));
         quiet = (ph % 3 == 2);
         fw = (field_w_q < 1) ? 1 : (field_w_q > MAX_WIDTH) ? MAX_WIDTH : int'(field_w_q);
         fh = (field_h_q < 1) ? 1 : (field_h_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(field_h_q);
         for (int n = 0; n < 25; n++) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 1)) begin
               x = 7'($urandom);
               y = 7'($urandom);
            end else begin
               x = 7'($urandom_range(0, fw - 1));
               y = 7'($urandom_range(0, fh - 1));
            end
            v = rand_vector();
            if (k < 30) add_req(OP_WR_VECTOR, x, y, v[15:0], v[31:16], 8'($urandom));
            else if (k < 55) add_req(OP_WR_NOISE, x, y, v[15:0], v[31:16], 8'($urandom));
            else if (k < 97) add_req(OP_COMPUTE, x, y, v[15:0], v[31:16], 8'($urandom));
            else add_req(2'd3, x, y, v[15:0], v[31:16], 8'($urandom));
         end
         drain();
      end

      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lic_pkg.sv
rtl/lic_div.sv
rtl/lic_store.sv
rtl/line_integral_convolution_pixel.sv
tb/line_integral_convolution_pixel_tb.sv
